// ===== design/ffba_pkg.sv =====
package ffba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int ID_W       = 16;
    localparam int AMT_W      = 16;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W      = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    localparam logic [CMP_W-1:0] SIZE_MAX_EXT = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);

    localparam logic       MODE_LOAD        = 1'b0;
    localparam logic       MODE_ALLOC       = 1'b1;
    localparam logic [1:0] ST_LOADED        = 2'd0;
    localparam logic [1:0] ST_ALLOCATED     = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOCATED = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL    = 2'd3;

    typedef struct packed {
        logic             mode;
        logic [ID_W-1:0]  item_id;
        logic [AMT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] echo_id;
        logic [1:0]      status;
        logic [ID_W-1:0] granted_block;
    } out_item_t;

    // request token that ripples down the cell chain
    typedef struct packed {
        logic             active;
        logic             is_load;
        logic             done;
        logic [CNT_W-1:0] countdown;
        logic [AMT_W-1:0] amount;
        logic [ID_W-1:0]  echo_id;
        logic [1:0]       status;
        logic [ID_W-1:0]  granted;
    } token_t;

endpackage

// ===== design/first_fit_block_allocator.sv =====
// Each request walks a chain of MAX_BLOCKS cells, one cell per cycle.
// A result passes through every cell register and then the output register before m_valid.
// Only one request is in flight: s_ready stays low until its result moves to the output register.
// A finished result may wait on m_ready while the next request is accepted.
// Reset (aresetn, synchronous, active low) empties the table; no clearing pass.
module first_fit_block_allocator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffba_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffba_pkg::out_item_t m_data
);
    import ffba_pkg::*;

    token_t           tok [MAX_BLOCKS+1];
    token_t           tail;
    logic [CNT_W-1:0] block_count_reg;
    logic             busy_reg;
    logic             m_valid_reg;
    out_item_t        out_reg;
    logic             hold_valid_reg;
    out_item_t        hold_reg;
    logic             accept;
    logic             full;
    logic             out_free;
    out_item_t        tail_item;

    assign accept   = s_valid && s_ready;
    assign full     = (block_count_reg == CNT_W'(MAX_BLOCKS));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        tok[0].active    = accept;
        tok[0].is_load   = (s_data.mode == MODE_LOAD);
        tok[0].done      = (s_data.mode == MODE_LOAD) && full;
        tok[0].countdown = block_count_reg;
        tok[0].amount    = s_data.amount;
        tok[0].echo_id   = s_data.item_id;
        tok[0].granted   = '0;
        if (s_data.mode == MODE_LOAD) begin
            tok[0].status = full ? ST_TABLE_FULL : ST_LOADED;
        end else begin
            tok[0].status = ST_NOT_ALLOCATED;
        end
    end

    for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
        ffba_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign tail      = tok[MAX_BLOCKS];
    assign tail_item = '{echo_id: tail.echo_id, status: tail.status,
                         granted_block: tail.granted};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= '0;
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            hold_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
                if (s_data.mode == MODE_LOAD && !full) begin
                    block_count_reg <= block_count_reg + 1'b1;
                end
            end
            if (tail.active) begin
                if (out_free) begin
                    out_reg     <= tail_item;
                    m_valid_reg <= 1'b1;
                    busy_reg    <= 1'b0;
                end else begin
                    hold_reg       <= tail_item;
                    hold_valid_reg <= 1'b1;
                end
            end else if (hold_valid_reg && out_free) begin
                out_reg        <= hold_reg;
                m_valid_reg    <= 1'b1;
                hold_valid_reg <= 1'b0;
                busy_reg       <= 1'b0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while another was in flight");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_ALLOCATED |-> m_data.granted_block == '0)
        else $error("granted_block nonzero without a grant");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        block_count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table size");

    a_hold_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> m_valid_reg && busy_reg)
        else $error("held result without a waiting output");
`endif

endmodule

// ===== design/ffba_cell.sv =====
module ffba_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  ffba_pkg::token_t tok_in,
    output ffba_pkg::token_t tok_out
);
    import ffba_pkg::*;

    logic [ID_W-1:0]      id_reg, id_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    token_t               tok_reg, tok_next;
    logic [CMP_W-1:0]     amt_ext;
    logic                 fits;
    logic                 here;

    assign amt_ext = CMP_W'(tok_in.amount);
    assign fits    = amt_ext <= CMP_W'(rem_reg);
    // countdown reaches zero at the first cell past the loaded blocks
    assign here    = (tok_in.countdown == '0);

    always_comb begin
        id_next  = id_reg;
        rem_next = rem_reg;
        tok_next = tok_in;
        if (tok_in.active && !tok_in.done) begin
            if (tok_in.is_load) begin
                if (here) begin
                    id_next       = tok_in.echo_id;
                    rem_next      = (amt_ext > SIZE_MAX_EXT) ? SIZE_BITS'(SIZE_MAX_EXT)
                                                             : SIZE_BITS'(amt_ext);
                    tok_next.done = 1'b1;
                end
            end else if (!here && fits) begin
                rem_next         = rem_reg - SIZE_BITS'(amt_ext);
                tok_next.done    = 1'b1;
                tok_next.status  = ST_ALLOCATED;
                tok_next.granted = id_reg;
            end
        end
        if (!here) begin
            tok_next.countdown = tok_in.countdown - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * (MAX_BLOCKS + 1) + 8;
    localparam int HOLD_CYCLES    = 300;

    class first_fit_scoreboard;
        logic [ID_W-1:0]  blk_id   [MAX_BLOCKS];
        logic [CMP_W-1:0] blk_room [MAX_BLOCKS];
        int unsigned      blk_used;
        out_item_t        answers_due [$];
        int unsigned      errors;
        int unsigned      n_req, n_loaded, n_full, n_granted, n_refused;

        function new();
            blk_used  = 0;
            errors    = 0;
            n_req     = 0;
            n_loaded  = 0;
            n_full    = 0;
            n_granted = 0;
            n_refused = 0;
        endfunction

        // first-fit prediction for one accepted request
        function void note_request(in_item_t req);
            out_item_t        ans;
            logic [CMP_W-1:0] cap;
            logic [CMP_W-1:0] need;
            ans.echo_id       = req.item_id;
            ans.status        = ST_NOT_ALLOCATED;
            ans.granted_block = '0;
            n_req++;
            if (req.mode == MODE_LOAD) begin
                if (blk_used >= MAX_BLOCKS) begin
                    ans.status = ST_TABLE_FULL;
                    n_full++;
                end else begin
                    cap = CMP_W'(req.amount);
                    if (cap > SIZE_MAX_EXT)
                        cap = SIZE_MAX_EXT;
                    blk_id[blk_used]   = req.item_id;
                    blk_room[blk_used] = cap;
                    blk_used++;
                    ans.status = ST_LOADED;
                    n_loaded++;
                end
            end else begin
                need = CMP_W'(req.amount);
                for (int k = 0; k < blk_used; k++) begin
                    if (ans.status == ST_NOT_ALLOCATED && need <= blk_room[k]) begin
                        blk_room[k]       = blk_room[k] - need;
                        ans.status        = ST_ALLOCATED;
                        ans.granted_block = blk_id[k];
                    end
                end
                if (ans.status == ST_ALLOCATED)
                    n_granted++;
                else
                    n_refused++;
            end
            answers_due.push_back(ans);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result echo_id=%h status=%0d granted=%h",
                         $time, got.echo_id, got.status, got.granted_block);
                errors++;
                return;
            end
            want = answers_due.pop_front();
            if (got.echo_id !== want.echo_id) begin
                $display("%0t: echo_id expected %h got %h", $time, want.echo_id, got.echo_id);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d (echo_id %h)",
                         $time, want.status, got.status, want.echo_id);
                errors++;
            end
            if (got.granted_block !== want.granted_block) begin
                $display("%0t: granted_block expected %h got %h (echo_id %h)",
                         $time, want.granted_block, got.granted_block, want.echo_id);
                errors++;
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int send_idle  = 0;
    int recv_stall = 0;
    int stall_req  = 0;

    first_fit_scoreboard sb;

    first_fit_block_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic in_item_t make_req(logic mode, logic [ID_W-1:0] id,
                                          logic [AMT_W-1:0] amount);
        in_item_t req;
        req.mode    = mode;
        req.item_id = id;
        req.amount  = amount;
        return req;
    endfunction

    // mostly allocations with small sizes so blocks drain slowly
    function automatic in_item_t rand_req();
        in_item_t req;
        int       pick;
        req.item_id = ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            req.mode   = MODE_LOAD;
            req.amount = AMT_W'($urandom);
        end else begin
            req.mode = MODE_ALLOC;
            if (pick < 10)
                req.amount = '0;
            else if (pick < 65)
                req.amount = AMT_W'($urandom_range(0, 255));
            else if (pick < 85)
                req.amount = AMT_W'($urandom_range(0, 4095));
            else
                req.amount = AMT_W'($urandom);
        end
        return req;
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_req(input in_item_t req);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_request(req);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        send_idle  = idle;
        recv_stall = stall;
        repeat (count) send_req(rand_req());
    endtask

    // result side: ready decided at the edge, handshake sampled mid-cycle
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_req > 0) begin
                stall_left = stall_req;
                stall_req  = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall);
            end
            @(negedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, then zero, maximum and small blocks for zero size and exact fit; then fill the table
        send_req(make_req(MODE_ALLOC, 16'h0001, 16'h0000));
        send_req(make_req(MODE_ALLOC, 16'hFFFF, 16'hFFFF));
        send_req(make_req(MODE_LOAD,  16'hFFFF, 16'h0000));
        send_req(make_req(MODE_ALLOC, 16'h0002, 16'h0000));
        send_req(make_req(MODE_ALLOC, 16'h0003, 16'h0001));
        send_req(make_req(MODE_LOAD,  16'h0000, 16'hFFFF));
        send_req(make_req(MODE_ALLOC, 16'h0004, 16'hFFFF));
        send_req(make_req(MODE_ALLOC, 16'h0005, 16'h0001));
        send_req(make_req(MODE_LOAD,  16'h1234, 16'd100));
        send_req(make_req(MODE_ALLOC, 16'h0006, 16'd60));
        send_req(make_req(MODE_ALLOC, 16'h0007, 16'd41));
        send_req(make_req(MODE_ALLOC, 16'h0008, 16'd40));
        for (int n = 0; n < MAX_BLOCKS - 3; n++)
            send_req(make_req(MODE_LOAD, ID_W'($urandom),
                              (n == 0) ? 16'hFFFF : AMT_W'($urandom)));
        send_req(make_req(MODE_LOAD,  16'hABCD, 16'h0010));
        send_req(make_req(MODE_ALLOC, 16'h0009, 16'h0000));
        send_req(make_req(MODE_ALLOC, 16'h000A, 16'hFFFF));

        run_phase(0,  0,  450);
        run_phase(88, 0,  450);
        run_phase(0,  88, 450);
        run_phase(31, 31, 450);

        // hold the result side so the input stalls behind the waiting and held results
        stall_req = HOLD_CYCLES;
        run_phase(0, 0, 200);

        s_valid <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d loads, %0d rejected on a full table, %0d grants, %0d refusals",
                 sb.n_req, sb.n_loaded, sb.n_full, sb.n_granted, sb.n_refused);
        $display("over four idle/stall mixes and a %0d-cycle result hold-off; %0d mismatches",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
